/* rtl/hvcc_pkg.sv */
// hvcc_pkg: shared types and constants for the hvcC parameter set extractor.
// No dependencies.
package hvcc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 16;
    localparam int unsigned HdrW   = 5;

    localparam logic [HdrW-1:0]  HdrCountByte = 5'd22;
    localparam logic [ByteW-1:0] VersionByte  = 8'd1;

    typedef struct packed {
        logic [ByteW-1:0] array_index;
        logic             empty_unit;
        logic             unit_last;
        logic             unit_first;
        logic [ByteW-1:0] payload_byte;
    } t_result;

endpackage

/* rtl/hvcc_parameter_set_extractor.sv */
// hvcc_parameter_set_extractor: hvcC record byte stream in, parameter set payload out.
// Path: input register, then parser logic, then the output stage register.
// Throughput: one byte per cycle while the master side does not back-pressure.
// Reset: synchronous, active low; parser returns to idle, both stages empty.
// Depends on hvcc_pkg, hvcc_parser, hvcc_out_stage.
module hvcc_parameter_set_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] record_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] array_index
    output logic        m_axis_tlast,   // unit_last
    output logic [1:0]  m_axis_tuser    // [0] unit_first, [1] empty_unit
);
    import hvcc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic       res_valid;
    t_result    res;
    logic       can_load;
    logic       step;
    t_result    out_res;

    assign step          = r_in_valid && (!res_valid || can_load);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    hvcc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hvcc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && res_valid),
        .i_res      (res),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_res      (out_res)
    );

    assign m_axis_tdata = {out_res.array_index, out_res.payload_byte};
    assign m_axis_tlast = out_res.unit_last;
    assign m_axis_tuser = {out_res.empty_unit, out_res.unit_first};

endmodule

/* rtl/hvcc_parser.sv */
// hvcc_parser: record parse state and the per-byte next-state / result logic.
// Depends on hvcc_pkg.
module hvcc_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_start,
    output logic                  o_res_valid,
    output hvcc_pkg::t_result     o_res
);
    import hvcc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_TYPE    = 3'd2,
        PH_UCNT_HI = 3'd3,
        PH_UCNT_LO = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_LEN_LO  = 3'd6,
        PH_PAYLOAD = 3'd7
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [HdrW-1:0]     r_hdr_cnt, n_hdr_cnt;
    logic [ByteW-1:0]    r_arrays_left, n_arrays_left;
    logic [ByteW-1:0]    r_cur_array, n_cur_array;
    logic [CountW-1:0]   r_units_left, n_units_left;
    logic [CountW-1:0]   r_bytes_left, n_bytes_left;
    logic [ByteW-1:0]    r_hi_hold, n_hi_hold;

    logic [CountW-1:0]   word;
    logic [CountW-1:0]   units_dec;
    logic [ByteW-1:0]    arrays_dec;
    logic [ByteW-1:0]    array_inc;
    logic                array_done;
    t_phase              unit_end_phase;

    assign word       = {r_hi_hold, i_byte};
    assign arrays_dec = r_arrays_left - 8'd1;
    assign array_inc  = r_cur_array + 8'd1;
    assign units_dec  = r_units_left - 16'd1;
    assign array_done = (arrays_dec == '0);
    assign unit_end_phase = (units_dec == '0) ? (array_done ? PH_IDLE : PH_TYPE) : PH_LEN_HI;

    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_arrays_left = r_arrays_left;
        n_cur_array   = r_cur_array;
        n_units_left  = r_units_left;
        n_bytes_left  = r_bytes_left;
        n_hi_hold     = r_hi_hold;
        o_res_valid   = 1'b0;
        o_res.payload_byte = i_byte;
        o_res.unit_first   = 1'b0;
        o_res.unit_last    = 1'b0;
        o_res.empty_unit   = 1'b0;
        o_res.array_index  = r_cur_array;

        if (i_start) begin
            n_phase       = (i_byte == VersionByte) ? PH_HEADER : PH_IDLE;
            n_hdr_cnt     = (i_byte == VersionByte) ? HdrW'(1) : '0;
            n_arrays_left = '0;
            n_cur_array   = '0;
            n_units_left  = '0;
            n_bytes_left  = '0;
            n_hi_hold     = '0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt >= HdrCountByte) begin
                        n_arrays_left = i_byte;
                        n_cur_array   = '0;
                        n_phase       = (i_byte == '0) ? PH_IDLE : PH_TYPE;
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + HdrW'(1);
                    end
                end
                PH_TYPE: begin
                    n_phase = PH_UCNT_HI;
                end
                PH_UCNT_HI: begin
                    n_hi_hold = i_byte;
                    n_phase   = PH_UCNT_LO;
                end
                PH_UCNT_LO: begin
                    n_units_left = word;
                    n_hi_hold    = '0;
                    if (word == '0) begin
                        n_arrays_left = arrays_dec;
                        n_cur_array   = array_inc;
                        n_phase       = array_done ? PH_IDLE : PH_TYPE;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_hi_hold = i_byte;
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (word == '0) begin
                        n_hi_hold          = '0;
                        o_res_valid        = 1'b1;
                        o_res.payload_byte = '0;
                        o_res.empty_unit   = 1'b1;
                        n_units_left       = units_dec;
                        n_phase            = unit_end_phase;
                        if (units_dec == '0) begin
                            n_arrays_left = arrays_dec;
                            n_cur_array   = array_inc;
                        end
                    end else begin
                        n_bytes_left = word;
                        n_hi_hold    = 8'd1;
                        n_phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid      = 1'b1;
                    o_res.unit_first = (r_hi_hold != '0);
                    o_res.unit_last  = (r_bytes_left == 16'd1);
                    n_hi_hold        = '0;
                    n_bytes_left     = r_bytes_left - 16'd1;
                    if (r_bytes_left == 16'd1) begin
                        n_units_left = units_dec;
                        n_phase      = unit_end_phase;
                        if (units_dec == '0) begin
                            n_arrays_left = arrays_dec;
                            n_cur_array   = array_inc;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_hdr_cnt     <= '0;
            r_arrays_left <= '0;
            r_cur_array   <= '0;
            r_units_left  <= '0;
            r_bytes_left  <= '0;
            r_hi_hold     <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_hdr_cnt     <= n_hdr_cnt;
            r_arrays_left <= n_arrays_left;
            r_cur_array   <= n_cur_array;
            r_units_left  <= n_units_left;
            r_bytes_left  <= n_bytes_left;
            r_hi_hold     <= n_hi_hold;
        end
    end

endmodule

/* rtl/hvcc_out_stage.sv */
// hvcc_out_stage: result register toward the master-side stream.
// Depends on hvcc_pkg.
module hvcc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hvcc_pkg::t_result  i_res,
    input  logic               i_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output hvcc_pkg::t_result  o_res
);
    import hvcc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
